// ===== hw/rtl/hrsl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrsl_pkg: shared types and codes for the hash ring shard lookup
// Request and response payloads, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package hrsl_pkg;

	localparam int MAX_SHARDS_DEF = 64;
	localparam int HASH_BITS_DEF  = 64;

	localparam logic       OP_INSERT = 1'b0;
	localparam logic       OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [13:0] NODE_SUM_MAX = 14'h3fff;

	typedef struct packed {
		logic        opcode;
		logic [63:0] hash_value;
		logic [7:0]  node_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  shard_index;
		logic [6:0]  shard_total;
		logic [13:0] node_total;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hash_ring_shard_lookup_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hash_ring_shard_lookup_top: sorted shard table with ring lookup
// Keeps shard hashes in ascending order in one synchronous memory, searches
// it by bisection and opens a slot for an insert by moving entries up.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_t: opcode, hash_value, node_count
//  rsp      out  rsp_valid/rsp_stall   rsp_t: status, shard_index, shard_total,
//                                             node_total
//
//  a request runs up to clog2(count+1) bisection steps, each a memory read and a
//  compare; an insert then moves each entry above the slot up by a read and a
//  write, then writes the new hash; full and empty cases skip the search
//  the next request is taken the cycle after the response is loaded
//  reset clears count and node sum; memory contents are don't-care until written
//  a held response lets the next item run; that item waits in S_DONE, stalling req
// ----------------------------------------------------------------------------
module hash_ring_shard_lookup_top
	import hrsl_pkg::*;
#(
	parameter int MAX_SHARDS = MAX_SHARDS_DEF,
	parameter int HASH_BITS  = HASH_BITS_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(MAX_SHARDS);
	localparam int CNT_W = $clog2(MAX_SHARDS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SHARDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	state_t               state_q;
	logic                 op_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [7:0]           nc_q;
	logic [CNT_W-1:0]     lo_q, hi_q, mid_q, rp_q;
	logic [CNT_W-1:0]     count_q;
	logic [13:0]          nodes_q;
	logic [1:0]           status_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	// memory
	logic [HASH_BITS-1:0] mem [MAX_SHARDS];
	logic [HASH_BITS-1:0] mem_rd_q;
	logic                 mem_re, mem_we;
	logic [IDX_W-1:0]     mem_ra, mem_wa;
	logic [HASH_BITS-1:0] mem_wd;

	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] rp_dec;
	logic [CNT_W-1:0] idx_res;
	logic [31:0]      idx32, cnt32;
	logic [14:0]      nodes_add;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign rp_dec = rp_q - CNT_W'(1);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = mid[IDX_W-1:0];
		mem_we = 1'b0;
		mem_wa = rp_q[IDX_W-1:0];
		mem_wd = mem_rd_q;
		case (state_q)
			S_RD: begin
				mem_re = (lo_q < hi_q);
			end
			S_SH_RD: begin
				if (rp_q > lo_q) begin
					mem_re = 1'b1;
					mem_ra = rp_dec[IDX_W-1:0];
				end else begin
					// slot is open, place the new hash
					mem_we = 1'b1;
					mem_wa = lo_q[IDX_W-1:0];
					mem_wd = hash_q;
				end
			end
			S_SH_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	assign nodes_add = {1'b0, nodes_q} + {7'd0, nc_q};
	// lookup past the last entry wraps around the ring
	assign idx_res   = (op_q == OP_LOOKUP && lo_q >= count_q) ? '0 : lo_q;
	assign idx32     = 32'(idx_res);
	assign cnt32     = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			nodes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req.opcode;
						hash_q   <= req.hash_value[HASH_BITS-1:0];
						nc_q     <= req.node_count;
						lo_q     <= '0;
						hi_q     <= count_q;
						if (req.opcode == OP_INSERT && count_q >= CNT_MAX) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (req.opcode == OP_LOOKUP && count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							state_q  <= S_RD;
						end
					end
				end
				S_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else if (op_q == OP_INSERT) begin
						rp_q    <= count_q;
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CMP: begin
					if (mem_rd_q > hash_q) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + CNT_W'(1);
					end
					state_q <= S_RD;
				end
				S_SH_RD: begin
					if (rp_q > lo_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q + CNT_W'(1);
						nodes_q <= (nodes_add > {1'b0, NODE_SUM_MAX}) ?
							NODE_SUM_MAX : nodes_add[13:0];
						state_q <= S_DONE;
					end
				end
				S_SH_WR: begin
					rp_q    <= rp_dec;
					state_q <= S_SH_RD;
				end
				S_DONE: begin
					if (!out_valid_q || !rsp_stall) begin
						out_q.status      <= status_q;
						out_q.shard_index <= (status_q == ST_OK) ? idx32[5:0] : 6'd0;
						out_q.shard_total <= cnt32[6:0];
						out_q.node_total  <= nodes_q;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// checks
	logic [31:0] max32;
	assign max32 = 32'(MAX_SHARDS);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("shard count above table size");

	a_nodes_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> nodes_q >= $past(nodes_q))
		else $error("node sum decreased");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && rsp.status == ST_FULL) |->
			rsp.shard_total == max32[6:0])
		else $error("full status with table not full");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_WR) |=> (state_q == S_SH_RD && rp_q == $past(rp_q) - CNT_W'(1)))
		else $error("shift pointer out of step");

endmodule

`default_nettype wire
